### hdl/red_pkg.sv
// Shared constants for the rounded Euclidean distance block.
// No dependencies; used by every module under hdl.
package red_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OUT_BITS       = 17;
	localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

endpackage

### hdl/red_prep.sv
// Front stages: absolute differences, squares and the squared sum.
// Depends on red_pkg for the default coordinate width.
module red_prep #(
	parameter int COORD_BITS = red_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   first_x,
	input  logic [COORD_BITS-1:0]   first_y,
	input  logic [COORD_BITS-1:0]   second_x,
	input  logic [COORD_BITS-1:0]   second_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2*COORD_BITS:0]   sum_sq
);

	localparam int CB = COORD_BITS;

	logic          valid_s1, valid_s2, valid_s3;
	logic          stall_s1, stall_s2, stall_s3;
	logic [CB-1:0] dx_s1, dy_s1;
	logic [2*CB-1:0] sqx_s2, sqy_s2;
	logic [2*CB:0] sum_s3;
	logic [CB:0]   diff_x, diff_y;
	logic [CB:0]   neg_x, neg_y;

	// hold a stage only while it is full and the one after it holds
	assign stall_s3 = valid_s3 && out_stall;
	assign stall_s2 = valid_s2 && stall_s3;
	assign stall_s1 = valid_s1 && stall_s2;
	assign in_stall = stall_s1;

	assign diff_x = {first_x[CB-1], first_x} - {second_x[CB-1], second_x};
	assign diff_y = {first_y[CB-1], first_y} - {second_y[CB-1], second_y};
	assign neg_x  = (CB+1)'(0) - diff_x;
	assign neg_y  = (CB+1)'(0) - diff_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= in_valid;
			if (!stall_s2) valid_s2 <= valid_s1;
			if (!stall_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && in_valid) begin
			dx_s1 <= diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
			dy_s1 <= diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];
		end
		if (!stall_s2 && valid_s1) begin
			sqx_s2 <= (2*CB)'(dx_s1) * (2*CB)'(dx_s1);
			sqy_s2 <= (2*CB)'(dy_s1) * (2*CB)'(dy_s1);
		end
		if (!stall_s3 && valid_s2) begin
			sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	assign out_valid = valid_s3;
	assign sum_sq    = sum_s3;

	a_sum_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!stall_s3 && valid_s2) |->
			sum_s3 == {1'b0, $past(sqx_s2)} + {1'b0, $past(sqy_s2)})
		else $error("squared sum does not match the registered squares");

endmodule

### hdl/red_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cell.
// Depends on red_pkg for the default coordinate width.
module red_sqrt_cell #(
	parameter int COORD_BITS = red_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [COORD_BITS+1:0]     in_rem,
	input  logic [COORD_BITS:0]       in_root,
	input  logic [2*COORD_BITS+1:0]   in_rad,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COORD_BITS+1:0]     out_rem,
	output logic [COORD_BITS:0]       out_root,
	output logic [2*COORD_BITS+1:0]   out_rad
);

	localparam int CB = COORD_BITS;
	localparam int RW = CB + 2;
	localparam int SW = 2*CB + 2;

	logic          valid_q;
	logic [RW-1:0] rem_q;
	logic [CB:0]   root_q;
	logic [SW-1:0] rad_q;
	logic [RW+1:0] partial;
	logic [RW+1:0] trial;
	logic [RW+1:0] diff;
	logic          fits;

	assign in_stall = valid_q && out_stall;

	// bring down the next pair of radicand bits and try a one in the root
	assign partial = {in_rem, in_rad[SW-1 -: 2]};
	assign trial   = {1'b0, in_root, 2'b01};
	assign fits    = partial >= trial;
	assign diff    = partial - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rem_q  <= fits ? diff[RW-1:0] : partial[RW-1:0];
			root_q <= {in_root[CB-1:0], fits};
			rad_q  <= {in_rad[SW-3:0], 2'b00};
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_rad   = rad_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> rem_q <= {root_q, 1'b0})
		else $error("square-root remainder above twice the partial root");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_q && $stable(root_q) && $stable(rem_q))
		else $error("cell contents changed while held");

endmodule

### hdl/red_round.sv
// Output stage: round the root to nearest, saturate, hold the result.
// Depends on red_pkg for the output width and saturation value.
module red_round #(
	parameter int COORD_BITS = red_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [COORD_BITS+1:0]         in_rem,
	input  logic [COORD_BITS:0]           in_root,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [red_pkg::OUT_BITS-1:0]  rounded_distance
);

	localparam int CB = COORD_BITS;
	localparam int RW = CB + 2;
	localparam int OB = red_pkg::OUT_BITS;
	localparam int WW = RW + OB;

	logic          valid_q;
	logic [OB-1:0] dist_q;
	logic [RW-1:0] root_ext;
	logic [RW-1:0] near;
	logic [WW-1:0] near_wide;
	logic          sat;

	assign in_stall = valid_q && out_stall;

	// rem = s - r*r, so rounding up is needed exactly when rem exceeds r
	assign root_ext  = {1'b0, in_root};
	assign near      = (in_rem > root_ext) ? root_ext + RW'(1) : root_ext;
	assign near_wide = WW'(near);
	assign sat       = near_wide > WW'(red_pkg::OUT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			dist_q <= sat ? red_pkg::OUT_MAX : near_wide[OB-1:0];
		end
	end

	assign out_valid        = valid_q;
	assign rounded_distance = dist_q;

endmodule

### hdl/rounded_euclidean_distance.sv
// Top level of the rounded Euclidean distance block (EUC_2D rule).
// Depends on red_pkg, red_prep, red_sqrt_cell and red_round.

// Takes a request holding two points and returns floor(sqrt(dx^2+dy^2)+0.5)
// as an unsigned 17-bit integer, saturated at 131071 for wide coordinates.
// The block is a fully pipelined chain: three front stages (absolute
// differences, squares, sum), then COORD_BITS+1 identical square-root cells
// that each settle one bit of the root, then one rounding and output stage.
// It accepts one request per clock while in_stall is low and returns one
// result per request, in order. Every stage holds only while it is full
// and its successor holds, so a stalled result does not block new
// requests while empty stages remain. Coordinates are two's complement,
// COORD_BITS wide. There is no state to initialise beyond the valid
// flags, which reset clears.
module rounded_euclidean_distance #(
	parameter int COORD_BITS = red_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [COORD_BITS-1:0]         first_x,
	input  logic [COORD_BITS-1:0]         first_y,
	input  logic [COORD_BITS-1:0]         second_x,
	input  logic [COORD_BITS-1:0]         second_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [red_pkg::OUT_BITS-1:0]  rounded_distance
);

	localparam int CB = COORD_BITS;
	localparam int NC = CB + 1;      // one cell per root bit
	localparam int RW = CB + 2;
	localparam int SW = 2*CB + 2;

	// chain links: index 0 feeds the first cell, index NC leaves the last
	logic          link_valid [NC+1];
	logic          link_stall [NC+1];
	logic [RW-1:0] link_rem   [NC+1];
	logic [CB:0]   link_root  [NC+1];
	logic [SW-1:0] link_rad   [NC+1];
	logic [2*CB:0] sum_sq;

	red_prep #(
		.COORD_BITS(CB)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.out_valid (link_valid[0]),
		.out_stall (link_stall[0]),
		.sum_sq    (sum_sq)
	);

	// start each root with empty remainder and root, radicand padded to pairs
	assign link_rem[0]  = '0;
	assign link_root[0] = '0;
	assign link_rad[0]  = {1'b0, sum_sq};

	for (genvar i = 0; i < NC; i++) begin : g_cell
		red_sqrt_cell #(
			.COORD_BITS(CB)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_stall  (link_stall[i]),
			.in_rem    (link_rem[i]),
			.in_root   (link_root[i]),
			.in_rad    (link_rad[i]),
			.out_valid (link_valid[i+1]),
			.out_stall (link_stall[i+1]),
			.out_rem   (link_rem[i+1]),
			.out_root  (link_root[i+1]),
			.out_rad   (link_rad[i+1])
		);
	end

	red_round #(
		.COORD_BITS(CB)
	) u_round (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (link_valid[NC]),
		.in_stall         (link_stall[NC]),
		.in_rem           (link_rem[NC]),
		.in_root          (link_root[NC]),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rounded_distance (rounded_distance)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the rounded Euclidean distance block (EUC_2D rule).
// Depends on red_pkg and rounded_euclidean_distance; needs no file or argument.
`timescale 1ns / 100ps

module testbench;

	localparam int COORD_BITS       = red_pkg::COORD_BITS_DEF;
	// Deep enough to cover the pipeline plus the output stage, with margin.
	localparam int SETTLE_CYCLES    = COORD_BITS + 10;
	localparam int RANDOM_REQUESTS  = 1800;
	// Long receiver hold-off: starts once this many results are through.
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 200;
	// Results window in which the receiver never stalls.
	localparam int CALM_FROM        = 1000;
	localparam int CALM_TO          = 1200;
	localparam longint TIMEOUT_NS   = 64'd10_000_000;

	typedef logic [COORD_BITS-1:0] coord_t;

	// One request: two points, plus how the sender treats it.
	typedef struct {
		coord_t fx, fy, sx, sy;
		bit     drain_first;   // hold back until every outstanding result is back
		bit     no_gap;        // present the next request straight after this one
	} pair_request_t;

	logic                         clk;
	logic                         arst_n           = 1'b0;
	logic                         in_valid         = 1'b0;
	logic                         in_stall;
	coord_t                       first_x          = '0;
	coord_t                       first_y          = '0;
	coord_t                       second_x         = '0;
	coord_t                       second_y         = '0;
	logic                         out_valid;
	logic                         out_stall        = 1'b0;
	logic [red_pkg::OUT_BITS-1:0] rounded_distance;

	pair_request_t                pending_requests[$];
	logic [red_pkg::OUT_BITS-1:0] distance_queue[$];
	pair_request_t                next_req;
	int                           send_gap         = 0;
	int                           hold_left        = 0;
	bit                           long_hold_done   = 1'b0;
	int                           results_seen     = 0;
	int                           failures         = 0;
	logic [red_pkg::OUT_BITS-1:0] want;

	rounded_euclidean_distance #(
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.first_x          (first_x),
		.first_y          (first_y),
		.second_x         (second_x),
		.second_y         (second_y),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rounded_distance (rounded_distance)
	);

	// Distance rounded to nearest: take the integer root of the squared sum,
	// then round up when the sum lies beyond r*r + r (sqrt(s) > r + 0.5).
	// The sum is an integer, so it can never sit exactly on the half.
	function automatic logic [red_pkg::OUT_BITS-1:0] euc2d_distance(coord_t ax,
			coord_t ay, coord_t bx, coord_t by);
		longint          dx, dy;
		longint unsigned sum, lo, hi, mid, root;
		dx = longint'($signed(ax)) - longint'($signed(bx));
		dy = longint'($signed(ay)) - longint'($signed(by));
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sum = dx * dx + dy * dy;
		// Binary search for the largest root whose square does not exceed the sum.
		lo = 0;
		hi = 64'h1_0000_0000;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= sum) lo = mid;
			else hi = mid;
		end
		root = lo;
		if (sum - root * root > root) root = root + 1;
		// Saturate where a wide coordinate pushes the result past the port.
		if (root > red_pkg::OUT_MAX) return red_pkg::OUT_MAX;
		return root[red_pkg::OUT_BITS-1:0];
	endfunction

	// Idle length once an idle is due: mostly short, now and then long.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_request(int ax, int ay, int bx, int by,
			bit drain_first = 1'b0, bit no_gap = 1'b0);
		pair_request_t req;
		req.fx          = coord_t'(ax);
		req.fy          = coord_t'(ay);
		req.sx          = coord_t'(bx);
		req.sy          = coord_t'(by);
		req.drain_first = drain_first;
		req.no_gap      = no_gap;
		pending_requests.insert(pending_requests.size(), req);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[rounded_euclidean_distance] ERROR");
		$finish;
	end

	// Sender: predict each accepted request, hold a stalled one, otherwise
	// idle for the drawn gap or present the next pending request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				distance_queue.insert(distance_queue.size(),
						euc2d_distance(first_x, first_y, second_x, second_y));
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].drain_first && distance_queue.size() != 0)) begin
					next_req = pending_requests.pop_front();
					first_x  <= next_req.fx;
					first_y  <= next_req.fy;
					second_x <= next_req.sx;
					second_y <= next_req.sy;
					in_valid <= 1'b1;
					send_gap <= (next_req.no_gap || $urandom_range(0, 99) < 60) ?
							0 : idle_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result against the oldest prediction,
	// then decide whether to stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (distance_queue.size() == 0) begin
					$error("rounded_distance: got %0d with no request outstanding",
							rounded_distance);
					failures++;
				end else begin
					want = distance_queue.pop_front();
					if (rounded_distance !== want) begin
						$error("rounded_distance: expected %0d, actual %0d",
								want, rounded_distance);
						failures++;
					end
				end
				results_seen++;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
				// Hold off long enough for the pipeline to fill and back-pressure the sender.
				out_stall      <= 1'b1;
				hold_left      <= LONG_HOLD_CYCLES - 1;
				long_hold_done <= 1'b1;
			end else if (!(results_seen >= CALM_FROM && results_seen < CALM_TO) &&
					$urandom_range(0, 99) < 20) begin
				out_stall <= 1'b1;
				hold_left <= idle_length() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int     kind;
		int     ax, ay;
		coord_t pick[4];

		// Directed requests: equal points, extremes, sign crossings, rounding edges.
		queue_request(0, 0, 0, 0);
		queue_request(32767, 32767, 32767, 32767);
		queue_request(-32768, -32768, -32768, -32768);
		queue_request(-32768, -32768, 32767, 32767);     // largest distance
		queue_request(32767, -32768, -32768, 32767);
		queue_request(-32768, 0, 32767, 0);
		queue_request(0, 32767, 0, -32768);
		queue_request(0, 0, -32768, -32768);
		queue_request(0, 0, 3, 4);
		queue_request(-1, -1, 2, 3);
		queue_request(0, 0, 1, 1);                       // sum sits on r*r + r
		queue_request(0, 0, 4, 2);                       // sum sits on r*r + r
		queue_request(0, 0, 3, 2);                       // just past the half, round up
		queue_request(0, 0, 2, 2);
		queue_request(0, 0, 1, 0);
		queue_request(-1, 0, 0, 0);
		queue_request(0, 0, 65, 72);                     // perfect square
		queue_request(21845, -21846, -21846, 21845);     // alternating bit patterns
		queue_request(-21846, 21845, 21845, -21846);
		queue_request(-1, -1, -1, -1);

		// Random requests; now and then pause the sender until the pipe is empty.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				pick[0] = coord_t'($urandom); pick[1] = coord_t'($urandom);
				pick[2] = coord_t'($urandom); pick[3] = coord_t'($urandom);
			end else if (kind < 80) begin
				// Close points: small roots, where rounding matters most.
				ax = int'($signed(coord_t'($urandom)));
				ay = int'($signed(coord_t'($urandom)));
				pick[0] = coord_t'(ax);
				pick[1] = coord_t'(ay);
				pick[2] = coord_t'(ax + $signed($urandom_range(0, 80)) - 40);
				pick[3] = coord_t'(ay + $signed($urandom_range(0, 80)) - 40);
			end else if (kind < 90) begin
				// Corners of the coordinate range, mixed with random values.
				for (int k = 0; k < 4; k++)
					case ($urandom_range(0, 4))
						0: pick[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
						1: pick[k] = {1'b0, {(COORD_BITS-1){1'b1}}};
						2: pick[k] = '0;
						3: pick[k] = '1;
						default: pick[k] = coord_t'($urandom);
					endcase
			end else begin
				// Points on a shared horizontal or vertical line.
				pick[0] = coord_t'($urandom); pick[1] = coord_t'($urandom);
				pick[2] = coord_t'($urandom); pick[3] = coord_t'($urandom);
				if (kind < 95) pick[2] = pick[0];
				else pick[3] = pick[1];
			end
			queue_request(int'($signed(pick[0])), int'($signed(pick[1])),
					int'($signed(pick[2])), int'($signed(pick[3])),
					(i % 600) == 0, i >= 900 && i < 1100);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Sample away from the active edge so that queue and valid agree.
		while (pending_requests.size() != 0 || in_valid || distance_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("[rounded_euclidean_distance] OK");
		end else begin
			$display("[rounded_euclidean_distance] ERROR");
		end
		$finish;
	end

endmodule
